@@ sv/scfl_pkg.sv @@
// Shared types and constants for the size-class free-list allocator.
// Used by the top, the class table, the checker and the testbench; depends on nothing.
`default_nettype none

package scfl_pkg;

   // Heap geometry: the word address port is 12 bits, which fixes the heap size.
   localparam int ADDR_W     = 12;
   localparam int HEAP_WORDS = 4096;
   localparam int LINK_W     = ADDR_W + 1;
   localparam int HEAD_TOP_W = ADDR_W + 1;
   localparam int CLASS_W    = 4;
   localparam int SIZE_W     = 8;
   localparam int STATUS_W   = 2;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_SIZE  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd2;

   // Command from the sequencer to the class table at the end of a request.
   typedef struct packed {
      logic               commit;
      logic               is_free;
      logic [CLASS_W-1:0] cls;
      logic [ADDR_W-1:0]  free_addr;
      logic [LINK_W-1:0]  link_data;
   } tbl_cmd_type;

   // Outcome computed by the class table for the request in hand.
   typedef struct packed {
      logic [ADDR_W-1:0]   address;
      logic [STATUS_W-1:0] status;
      logic [LINK_W-1:0]   op_head;
   } tbl_rsp_type;

endpackage

`default_nettype wire

@@ sv/size_class_free_list_allocator_top.sv @@
// Top level of the size-class free-list allocator: request sequencer, link
// store and result register. Depends on scfl_pkg, scfl_ram, scfl_class_table.
//
// Each request allocates or frees a block of 1 to SIZE_CLASSES*WORD_BYTES bytes
// and produces exactly one response. On the transfer cycle the head link of its
// class is read from the link store, which registers it. In the work state,
// once the output register is free or emptying, the class table is updated, a
// freed block's link is written and the response is loaded into the output
// register. No new request is taken until that commit, so a request is not
// taken while the last is still in hand; a further one can be taken the cycle
// after the commit. Free addresses are not checked; a bad size gives status 1,
// and running out of heap for a new chunk gives status 2. The link store needs
// no clearing after reset.
`default_nettype none

module size_class_free_list_allocator_top #(
   parameter int CHUNK_WORDS  = 508,
   parameter int SIZE_CLASSES = 4,
   parameter int WORD_BYTES   = 8
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic                           req_kind,
   input  wire logic [scfl_pkg::SIZE_W-1:0]    req_size_bytes,
   input  wire logic [scfl_pkg::ADDR_W-1:0]    req_block_address,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic      [scfl_pkg::ADDR_W-1:0]    rsp_address,
   output logic      [scfl_pkg::STATUS_W-1:0]  rsp_status
);

   localparam int MAX_BYTES = SIZE_CLASSES * WORD_BYTES;

   typedef enum logic {S_IDLE, S_WORK} state_type;

   state_type                         state_ff;
   logic                              op_kind_ff;
   logic                              op_bad_ff;
   logic [scfl_pkg::CLASS_W-1:0]      op_cls_ff;
   logic [scfl_pkg::ADDR_W-1:0]       op_addr_ff;
   logic                              rsp_valid_ff;
   logic [scfl_pkg::ADDR_W-1:0]       rsp_address_ff;
   logic [scfl_pkg::STATUS_W-1:0]     rsp_status_ff;

   logic                              req_xfer;
   logic                              req_bad;
   logic [scfl_pkg::CLASS_W-1:0]      req_cls;
   logic [scfl_pkg::LINK_W-1:0]       query_head;
   logic [scfl_pkg::LINK_W-1:0]       link_rd_data;
   logic                              commit;
   scfl_pkg::tbl_cmd_type             tbl_cmd;
   scfl_pkg::tbl_rsp_type             tbl_rsp;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;

   assign req_bad = (req_size_bytes == '0) ||
                    (req_size_bytes > scfl_pkg::SIZE_W'(MAX_BYTES));

   // The class is the number of whole words that the size exceeds, found by
   // comparing against each class boundary.
   always_comb begin
      req_cls = '0;
      for (int k = 1; k < SIZE_CLASSES; k++) begin
         if (req_size_bytes > scfl_pkg::SIZE_W'(k * WORD_BYTES)) begin
            req_cls = scfl_pkg::CLASS_W'(k);
         end
      end
   end

   // The response register must be free, or emptying this cycle, to finish.
   assign commit = (state_ff == S_WORK) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      tbl_cmd.commit    = commit && !op_bad_ff;
      tbl_cmd.is_free   = (op_kind_ff == scfl_pkg::KIND_FREE);
      tbl_cmd.cls       = op_cls_ff;
      tbl_cmd.free_addr = op_addr_ff;
      tbl_cmd.link_data = link_rd_data;
   end

   scfl_class_table #(
      .SIZE_CLASSES (SIZE_CLASSES),
      .CHUNK_WORDS  (CHUNK_WORDS)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .query_cls  (req_cls),
      .query_head (query_head),
      .cmd        (tbl_cmd),
      .rsp        (tbl_rsp)
   );

   scfl_ram #(
      .WIDTH (scfl_pkg::LINK_W),
      .DEPTH (scfl_pkg::HEAP_WORDS)
   ) u_link_ram (
      .clock      (clock),
      .wr_en      (tbl_cmd.commit && tbl_cmd.is_free),
      .wr_addr    (op_addr_ff),
      .wr_data    (tbl_rsp.op_head),
      .rd_en      (req_xfer),
      .rd_addr    (query_head[scfl_pkg::ADDR_W-1:0]),
      .rd_data_ff (link_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_xfer) begin
                  state_ff <= S_WORK;
               end
            end
            S_WORK: begin
               if (commit) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      if (req_xfer) begin
         op_kind_ff <= req_kind;
         op_bad_ff  <= req_bad;
         op_cls_ff  <= req_cls;
         op_addr_ff <= req_block_address;
      end

      if (commit) begin
         if (op_bad_ff) begin
            rsp_address_ff <= '0;
            rsp_status_ff  <= scfl_pkg::STATUS_BAD_SIZE;
         end else begin
            rsp_address_ff <= tbl_rsp.address;
            rsp_status_ff  <= tbl_rsp.status;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_address = rsp_address_ff;
   assign rsp_status  = rsp_status_ff;

endmodule

`default_nettype wire

@@ sv/scfl_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; no package needed.
`default_nettype none

module scfl_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ sv/scfl_class_table.sv @@
// Per-class list heads, carve cursors and the heap bump pointer, with the
// allocate and free decision logic. Depends on scfl_pkg.
`default_nettype none

module scfl_class_table #(
   parameter int SIZE_CLASSES = 4,
   parameter int CHUNK_WORDS  = 508
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [scfl_pkg::CLASS_W-1:0]  query_cls,
   output logic      [scfl_pkg::LINK_W-1:0]   query_head,
   input  wire scfl_pkg::tbl_cmd_type         cmd,
   output scfl_pkg::tbl_rsp_type              rsp
);

   localparam int CW  = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
   localparam int CLW = $clog2(CHUNK_WORDS + 1);
   localparam int HTW = scfl_pkg::HEAD_TOP_W;
   localparam int AW  = scfl_pkg::ADDR_W;

   logic [scfl_pkg::LINK_W-1:0] head_ff   [SIZE_CLASSES];
   logic [scfl_pkg::LINK_W-1:0] head_in   [SIZE_CLASSES];
   logic [AW-1:0]               cursor_ff [SIZE_CLASSES];
   logic [AW-1:0]               cursor_in [SIZE_CLASSES];
   logic [CLW-1:0]              left_ff   [SIZE_CLASSES];
   logic [CLW-1:0]              left_in   [SIZE_CLASSES];
   logic [CLW-1:0]              carve_count [SIZE_CLASSES];
   logic [HTW-1:0]              heap_top_ff;
   logic [HTW-1:0]              heap_top_in;

   // Elements per chunk for each class, fixed at elaboration.
   for (genvar c = 0; c < SIZE_CLASSES; c++) begin : g_count
      localparam int Count = CHUNK_WORDS / (c + 1);
      assign carve_count[c] = CLW'(Count);
   end

   assign query_head = head_ff[query_cls[CW-1:0]];

   always_comb begin
      logic [CW-1:0]               oc;
      logic [scfl_pkg::LINK_W-1:0] head;
      logic [AW-1:0]               elem_words;
      logic [HTW:0]                top_sum;
      logic                        chunk_fits;

      oc         = cmd.cls[CW-1:0];
      head       = head_ff[oc];
      elem_words = AW'(oc) + AW'(1);
      top_sum    = {1'b0, heap_top_ff} + (HTW+1)'(CHUNK_WORDS);
      chunk_fits = (carve_count[oc] != '0) && (top_sum <= (HTW+1)'(scfl_pkg::HEAP_WORDS));

      for (int c = 0; c < SIZE_CLASSES; c++) begin
         head_in[c]   = head_ff[c];
         cursor_in[c] = cursor_ff[c];
         left_in[c]   = left_ff[c];
      end
      heap_top_in = heap_top_ff;

      rsp.op_head = head;
      rsp.address = '0;
      rsp.status  = scfl_pkg::STATUS_DONE;

      if (cmd.is_free) begin
         head_in[oc] = {1'b1, cmd.free_addr};
      end else if (head[AW]) begin
         // Pop: the link read from the heap word becomes the new head.
         rsp.address = head[AW-1:0];
         head_in[oc] = cmd.link_data;
      end else if (left_ff[oc] == '0) begin
         if (chunk_fits) begin
            rsp.address  = heap_top_ff[AW-1:0];
            cursor_in[oc] = heap_top_ff[AW-1:0] + elem_words;
            left_in[oc]   = carve_count[oc] - CLW'(1);
            heap_top_in   = top_sum[HTW-1:0];
         end else begin
            rsp.status = scfl_pkg::STATUS_EXHAUSTED;
         end
      end else begin
         rsp.address  = cursor_ff[oc];
         cursor_in[oc] = cursor_ff[oc] + elem_words;
         left_in[oc]   = left_ff[oc] - CLW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < SIZE_CLASSES; c++) begin
            head_ff[c]   <= '0;
            cursor_ff[c] <= '0;
            left_ff[c]   <= '0;
         end
         heap_top_ff <= '0;
      end else if (cmd.commit) begin
         for (int c = 0; c < SIZE_CLASSES; c++) begin
            head_ff[c]   <= head_in[c];
            cursor_ff[c] <= cursor_in[c];
            left_ff[c]   <= left_in[c];
         end
         heap_top_ff <= heap_top_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/scfl_checker.sv @@
// Port-level checks for the size-class free-list allocator, bound to the top.
// Depends on scfl_pkg.
`default_nettype none

module scfl_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [scfl_pkg::ADDR_W-1:0]   rsp_address,
   input wire logic [scfl_pkg::STATUS_W-1:0] rsp_status
);

   // A request occupies the sequencer for the following cycle.
   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while the previous one was in hand");

   // Failed requests never hand out an address other than zero.
   a_fail_zero_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != scfl_pkg::STATUS_DONE |-> rsp_address == '0)
      else $error("failed response carries a non-zero address");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == scfl_pkg::STATUS_DONE ||
                     rsp_status == scfl_pkg::STATUS_BAD_SIZE ||
                     rsp_status == scfl_pkg::STATUS_EXHAUSTED))
      else $error("response status outside the defined codes");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_address) && $stable(rsp_status))
      else $error("stalled response changed");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response presented straight after reset");

endmodule

bind size_class_free_list_allocator_top scfl_checker u_scfl_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_address (rsp_address),
   .rsp_status  (rsp_status)
);

`default_nettype wire

@@ dv/size_class_free_list_allocator_tb.sv @@
// Testbench for size_class_free_list_allocator_top: directed and random allocate and free
// requests, checked against an in-bench model of the size-class free lists and bump pointer.
// Depends on scfl_pkg and the allocator RTL only.
`timescale 1ns / 1ps

module size_class_free_list_allocator_top_tb;

   localparam int CHUNK_WORDS     = 508;
   localparam int SIZE_CLASSES    = 4;
   localparam int WORD_BYTES      = 8;
   localparam int MAX_BYTES       = SIZE_CLASSES * WORD_BYTES;
   localparam int RANDOM_REQUESTS = 1930;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int DRAIN_CYCLES    = 8;

   typedef struct packed {
      logic [scfl_pkg::ADDR_W-1:0]   address;
      logic [scfl_pkg::STATUS_W-1:0] status;
   } reply_type;

   typedef struct packed {
      logic                        kind;
      logic [scfl_pkg::SIZE_W-1:0] size;
      logic [scfl_pkg::ADDR_W-1:0] where;
      reply_type                   reply;
   } request_type;

   typedef struct packed {
      logic [scfl_pkg::ADDR_W-1:0]  addr;
      logic [scfl_pkg::CLASS_W-1:0] cls;
   } block_type;

   logic                          clock             = 1'b0;
   logic                          reset             = 1'b1;
   logic                          req_valid         = 1'b0;
   logic                          req_kind          = scfl_pkg::KIND_ALLOC;
   logic [scfl_pkg::SIZE_W-1:0]   req_size_bytes    = '0;
   logic [scfl_pkg::ADDR_W-1:0]   req_block_address = '0;
   logic                          rsp_stall         = 1'b0;
   logic                          req_stall;
   logic                          rsp_valid;
   logic [scfl_pkg::ADDR_W-1:0]   rsp_address;
   logic [scfl_pkg::STATUS_W-1:0] rsp_status;

   // Model state of the allocator.
   logic [scfl_pkg::LINK_W-1:0] link_mem     [scfl_pkg::HEAP_WORDS];
   logic [scfl_pkg::LINK_W-1:0] class_head   [SIZE_CLASSES];
   logic [scfl_pkg::ADDR_W-1:0] carve_cursor [SIZE_CLASSES];
   int                          carve_left   [SIZE_CLASSES];
   int                          heap_top;

   request_type request_queue[$];
   reply_type   owed_replies[$];
   block_type   live_blocks[$];
   request_type in_flight;

   int total_requests = 0;
   int transfers_in   = 0;
   int replies_seen   = 0;
   int mismatches     = 0;
   int cycles         = 0;
   int allocs         = 0;
   int frees          = 0;
   int bad_sizes      = 0;
   int exhausted      = 0;

   size_class_free_list_allocator_top #(
      .CHUNK_WORDS  (CHUNK_WORDS),
      .SIZE_CLASSES (SIZE_CLASSES),
      .WORD_BYTES   (WORD_BYTES)
   ) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_size_bytes    (req_size_bytes),
      .req_block_address (req_block_address),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_address       (rsp_address),
      .rsp_status        (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Works out the reply to one request and updates the free lists and carving state.
   function automatic reply_type allocate_or_free(logic kind,
                                                  logic [scfl_pkg::SIZE_W-1:0] size,
                                                  logic [scfl_pkg::ADDR_W-1:0] where);
      reply_type r;
      int        cls;
      int        n;
      int        count;
      r.address = '0;
      r.status  = scfl_pkg::STATUS_DONE;
      if (size == 0 || int'(size) > MAX_BYTES) begin
         r.status = scfl_pkg::STATUS_BAD_SIZE;
         return r;
      end
      cls = (int'(size) - 1) / WORD_BYTES;
      n   = cls + 1;
      if (kind == scfl_pkg::KIND_FREE) begin
         link_mem[where] = class_head[cls];
         class_head[cls] = {1'b1, where};
      end else if (class_head[cls][scfl_pkg::ADDR_W]) begin
         r.address       = class_head[cls][scfl_pkg::ADDR_W-1:0];
         class_head[cls] = link_mem[r.address];
      end else begin
         if (carve_left[cls] == 0) begin
            count = CHUNK_WORDS / n;
            if (count == 0 || heap_top + CHUNK_WORDS > scfl_pkg::HEAP_WORDS) begin
               r.status = scfl_pkg::STATUS_EXHAUSTED;
               return r;
            end
            carve_cursor[cls] = scfl_pkg::ADDR_W'(heap_top);
            carve_left[cls]   = count;
            heap_top          = heap_top + CHUNK_WORDS;
         end
         r.address         = carve_cursor[cls];
         carve_cursor[cls] = carve_cursor[cls] + scfl_pkg::ADDR_W'(n);
         carve_left[cls]   = carve_left[cls] - 1;
      end
      return r;
   endfunction

   task automatic add_request(logic kind, logic [scfl_pkg::SIZE_W-1:0] size,
                              logic [scfl_pkg::ADDR_W-1:0] where);
      request_type rq;
      block_type   blk;
      rq.kind  = kind;
      rq.size  = size;
      rq.where = where;
      rq.reply = allocate_or_free(kind, size, where);
      if (kind == scfl_pkg::KIND_ALLOC) allocs++;
      else frees++;
      if (rq.reply.status == scfl_pkg::STATUS_BAD_SIZE) begin
         bad_sizes++;
      end else if (rq.reply.status == scfl_pkg::STATUS_EXHAUSTED) begin
         exhausted++;
      end else if (kind == scfl_pkg::KIND_ALLOC) begin
         blk.addr = rq.reply.address;
         blk.cls  = scfl_pkg::CLASS_W'((int'(size) - 1) / WORD_BYTES);
         live_blocks.push_back(blk);
      end
      request_queue.push_back(rq);
   endtask

   // The run is split in thirds by transfer count: sender-light idling, then receiver-light
   // idling, then none at all.
   function automatic int idle_phase();
      if (total_requests == 0) return 0;
      return (transfers_in * 3) / total_requests;
   endfunction

   function automatic int send_idle_pct();
      case (idle_phase())
         0: return 21;
         1: return 58;
         default: return 0;
      endcase
   endfunction

   function automatic int recv_stall_pct();
      case (idle_phase())
         0: return 58;
         1: return 21;
         default: return 0;
      endcase
   endfunction

   task automatic note_mismatch(string what, reply_type want);
      mismatches++;
      if (mismatches <= 10)
         $display("Mismatch (%s): expected address %0d status %0d, got address %0d status %0d",
                  what, want.address, want.status, rsp_address, rsp_status);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d replies outstanding", cycles,
                  owed_replies.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Driver: a new transfer is offered only once the previous one has gone through.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            owed_replies.push_back(in_flight.reply);
            transfers_in++;
         end
         if (!req_valid || !req_stall) begin
            if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
               in_flight = request_queue.pop_front();
               req_valid         <= 1'b1;
               req_kind          <= in_flight.kind;
               req_size_bytes    <= in_flight.size;
               req_block_address <= in_flight.where;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compares each reply with the oldest one owed and drives the stall.
   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            replies_seen++;
            if (owed_replies.size() == 0) begin
               want = '0;
               note_mismatch("no reply owed", want);
            end else begin
               want = owed_replies.pop_front();
               if (rsp_address !== want.address || rsp_status !== want.status)
                  note_mismatch("wrong field", want);
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct());
      end
   end

   initial begin
      int                          roll;
      int                          cls;
      int                          pick;
      block_type                   blk;
      logic [scfl_pkg::SIZE_W-1:0] size;
      logic [scfl_pkg::ADDR_W-1:0] where;

      foreach (link_mem[i]) link_mem[i] = '0;
      for (int c = 0; c < SIZE_CLASSES; c++) begin
         class_head[c]   = '0;
         carve_cursor[c] = '0;
         carve_left[c]   = 0;
      end
      heap_top = 0;

      // Class boundaries first, each allocation carving from its class's first chunk.
      add_request(scfl_pkg::KIND_ALLOC, 8'd1, 12'hFFF);
      add_request(scfl_pkg::KIND_ALLOC, 8'd8, 12'h000);
      add_request(scfl_pkg::KIND_ALLOC, 8'd9, 12'hAAA);
      add_request(scfl_pkg::KIND_ALLOC, 8'd16, 12'h555);
      add_request(scfl_pkg::KIND_ALLOC, 8'd17, 12'h000);
      add_request(scfl_pkg::KIND_ALLOC, 8'd24, 12'hFFF);
      add_request(scfl_pkg::KIND_ALLOC, 8'd25, 12'h123);
      add_request(scfl_pkg::KIND_ALLOC, 8'd32, 12'h000);
      // Sizes outside the classes, on allocate and on free.
      add_request(scfl_pkg::KIND_ALLOC, 8'd0, 12'h000);
      add_request(scfl_pkg::KIND_ALLOC, 8'd33, 12'h000);
      add_request(scfl_pkg::KIND_ALLOC, 8'd255, 12'hFFF);
      add_request(scfl_pkg::KIND_FREE, 8'd0, 12'hFFF);
      add_request(scfl_pkg::KIND_FREE, 8'd200, 12'h000);
      // A freed block comes straight back on the next allocation of its class.
      add_request(scfl_pkg::KIND_FREE, 8'd1, 12'h001);
      add_request(scfl_pkg::KIND_ALLOC, 8'd5, 12'h000);
      // Frees of addresses that were never handed out are taken as they are.
      add_request(scfl_pkg::KIND_FREE, 8'd32, 12'hFFF);
      add_request(scfl_pkg::KIND_FREE, 8'd28, 12'd2540);
      add_request(scfl_pkg::KIND_ALLOC, 8'd30, 12'h000);
      add_request(scfl_pkg::KIND_ALLOC, 8'd32, 12'h000);
      add_request(scfl_pkg::KIND_ALLOC, 8'd25, 12'h000);

      // Allocation-heavy, large-class traffic until the heap runs dry, then a balanced mix
      // so that popped free-list entries dominate.
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         roll  = $urandom_range(99);
         where = scfl_pkg::ADDR_W'($urandom);
         if (roll < 5) begin
            size = ($urandom_range(3) == 0) ? '0 :
                   scfl_pkg::SIZE_W'($urandom_range(MAX_BYTES + 1, 255));
            add_request(1'($urandom), size, where);
         end else if ($urandom_range(99) < ((exhausted == 0) ? 88 : 45)) begin
            if (exhausted == 0 && $urandom_range(99) < 70) cls = SIZE_CLASSES - 1;
            else cls = $urandom_range(SIZE_CLASSES - 1);
            add_request(scfl_pkg::KIND_ALLOC,
                        scfl_pkg::SIZE_W'(cls * WORD_BYTES + $urandom_range(1, WORD_BYTES)),
                        where);
         end else if (live_blocks.size() == 0 || $urandom_range(9) == 0) begin
            add_request(scfl_pkg::KIND_FREE, scfl_pkg::SIZE_W'($urandom_range(1, MAX_BYTES)),
                        where);
         end else begin
            pick = $urandom_range(live_blocks.size() - 1);
            blk  = live_blocks[pick];
            // Now and then the block stays listed, so it may be freed a second time later on.
            if ($urandom_range(19) != 0) live_blocks.delete(pick);
            add_request(scfl_pkg::KIND_FREE,
                        scfl_pkg::SIZE_W'(int'(blk.cls) * WORD_BYTES +
                                          $urandom_range(1, WORD_BYTES)),
                        blk.addr);
         end
      end
      total_requests = request_queue.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (transfers_in != total_requests) @(posedge clock);
      while (owed_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests (%0d allocations, %0d frees) and checked %0d replies.",
               total_requests, allocs, frees, replies_seen);
      $display("Bad sizes: %0d, heap exhausted: %0d, heap used: %0d of %0d words.",
               bad_sizes, exhausted, heap_top, scfl_pkg::HEAP_WORDS);
      if (mismatches == 0 && owed_replies.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches, %0d replies never arrived", mismatches, owed_replies.size());
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/scfl_pkg.sv
sv/scfl_ram.sv
sv/scfl_class_table.sv
sv/size_class_free_list_allocator_top.sv
sv/scfl_checker.sv
dv/size_class_free_list_allocator_tb.sv
